### hdl/decimal_count_text_generator_unit_assert.svh
// Assertion macros used by the port-level checker.
`ifndef DECIMAL_COUNT_TEXT_GENERATOR_UNIT_ASSERT_SVH
`define DECIMAL_COUNT_TEXT_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define DCG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define DCG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/dcg_pkg.sv
// Shared types and constants of the decimal count text generator.
`default_nettype none
package dcg_pkg;

  localparam int unsigned OFF_W  = 63;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned BIT_W  = 6;
  localparam int unsigned LEN_W  = 5;
  localparam int unsigned CHAR_W = 6;

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 6'd32;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [LEN_W-1:0]  BAND_STOP  = 5'd19;

  typedef struct packed {
    logic             done;
    logic             to_zero;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] pos;
  } seek_res_t;

  typedef enum logic [6:0] {
    SK_IDLE = 7'b0000001,
    SK_CNT  = 7'b0000010,
    SK_MUL  = 7'b0000100,
    SK_CMP  = 7'b0001000,
    SK_DIV  = 7'b0010000,
    SK_ADD  = 7'b0100000,
    SK_BCD  = 7'b1000000
  } seek_state_e;

  typedef enum logic [1:0] {
    T_IDLE = 2'b01,
    T_SEEK = 2'b10
  } top_state_e;

endpackage
`default_nettype wire

### hdl/dcg_seek.sv
// Seek sequencer: band search, bit-serial divide and bit-serial BCD conversion.
`default_nettype none
module dcg_seek #(
  parameter int unsigned MAX_DIGITS = 20
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [dcg_pkg::OFF_W-1:0]  offset_i,
  output dcg_pkg::seek_res_t              res_o,
  output logic [MAX_DIGITS-1:0][3:0]      digits_o
);
  import dcg_pkg::*;

  localparam int unsigned DW = MAX_DIGITS * 4;

  seek_state_e          state_q, state_d;
  logic [WORD_W-1:0]    rem_q, rem_d, base_q, base_d, cnt_q, cnt_d, band_q, band_d;
  logic [LEN_W-1:0]     d_q, d_d, mcnt_q, mcnt_d, dp1;
  logic [BIT_W-1:0]     bit_q, bit_d;
  logic [5:0]           part_q, part_d, part2;
  logic                 ge;
  logic [DW-1:0]        dig_q, dig_d, adj;
  seek_res_t            res_q, res_d;

  assign dp1 = d_q + 1'b1;
  assign part2 = {part_q[4:0], rem_q[WORD_W-1]};
  assign ge = part2 >= {1'b0, dp1};

  // Add three to every BCD digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj[4*i +: 4] = (dig_q[4*i +: 4] >= 4'd5) ? dig_q[4*i +: 4] + 4'd3 : dig_q[4*i +: 4];
    end
  end

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    base_d  = base_q;
    cnt_d   = cnt_q;
    band_d  = band_q;
    d_d     = d_q;
    mcnt_d  = mcnt_q;
    bit_d   = bit_q;
    part_d  = part_q;
    dig_d   = dig_q;
    res_d   = res_q;
    res_d.done = 1'b0;
    unique case (state_q)
      SK_IDLE: begin
        if (start_i) begin
          rem_d   = {1'b0, offset_i};
          base_d  = WORD_W'(1);
          d_d     = LEN_W'(1);
          state_d = SK_CNT;
        end
      end
      SK_CNT: begin
        if (d_q > LEN_W'(MAX_DIGITS)) begin
          res_d.done    = 1'b1;
          res_d.to_zero = 1'b1;
          state_d       = SK_IDLE;
        end else if (d_q >= BAND_STOP) begin
          part_d  = '0;
          bit_d   = '0;
          state_d = SK_DIV;
        end else begin
          cnt_d   = (d_q == LEN_W'(1)) ? WORD_W'(10) : (base_q << 3) + base_q;
          band_d  = '0;
          mcnt_d  = dp1;
          state_d = SK_MUL;
        end
      end
      SK_MUL: begin
        band_d = band_q + cnt_q;
        mcnt_d = mcnt_q - 1'b1;
        if (mcnt_q == LEN_W'(1)) state_d = SK_CMP;
      end
      SK_CMP: begin
        if (rem_q < band_q) begin
          part_d  = '0;
          bit_d   = '0;
          state_d = SK_DIV;
        end else begin
          rem_d   = rem_q - band_q;
          base_d  = (base_q << 3) + (base_q << 1);
          d_d     = d_q + 1'b1;
          state_d = SK_CNT;
        end
      end
      SK_DIV: begin
        part_d = ge ? part2 - {1'b0, dp1} : part2;
        rem_d  = {rem_q[WORD_W-2:0], ge};
        bit_d  = bit_q + 1'b1;
        if (bit_q == BIT_W'(WORD_W - 1)) state_d = SK_ADD;
      end
      SK_ADD: begin
        rem_d   = rem_q + ((d_q == LEN_W'(1)) ? WORD_W'(0) : base_q);
        dig_d   = '0;
        bit_d   = '0;
        state_d = SK_BCD;
      end
      SK_BCD: begin
        dig_d = {adj[DW-2:0], rem_q[WORD_W-1]};
        rem_d = rem_q << 1;
        bit_d = bit_q + 1'b1;
        if (bit_q == BIT_W'(WORD_W - 1)) begin
          res_d.done    = 1'b1;
          res_d.to_zero = 1'b0;
          res_d.len     = d_q;
          res_d.pos     = part_q[LEN_W-1:0];
          state_d       = SK_IDLE;
        end
      end
      default: state_d = SK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SK_IDLE;
      d_q     <= LEN_W'(1);
      mcnt_q  <= '0;
      bit_q   <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      d_q     <= d_d;
      mcnt_q  <= mcnt_d;
      bit_q   <= bit_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    base_q <= base_d;
    cnt_q  <= cnt_d;
    band_q <= band_d;
    part_q <= part_d;
    dig_q  <= dig_d;
  end

  assign res_o = res_q;
  assign digits_o = dig_q;

endmodule
`default_nettype wire

### hdl/decimal_count_text_generator_unit.sv
// Top level of the decimal count text generator.
// The block streams the text "0 1 2 3 ... 9 10 11 ..." one character a word.
// Input channel s_axis: tuser selects the kind of word (0 = seek, 1 = emit),
// tdata carries the byte offset for a seek and is ignored for an emit.
// Output channel m_axis: one word per emit, tdata[5:0] holds the ASCII code
// of a digit or of the space that follows each number.
// Emit: the result word appears in the cycle after acceptance, and emits are
// taken back to back, one per cycle, as long as the receiver keeps up.
// Seek: gives no word. It walks the digit-length bands, one band per digit
// count d, then divides bit-serially, adds the band base and converts to
// BCD by double dabble; s_axis_tready stays low until the seek is done.
// The output register lets the next emit in as its word is taken, so a stalled
// receiver holds the word and tready drops only if that word is not taken.
// Reset puts the block at offset zero, ready for the character '0'.
// Past the last number of MAX_DIGITS digits the count wraps to zero.
`default_nettype none
module decimal_count_text_generator_unit #(
  parameter int unsigned MAX_DIGITS = 20
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,   // [62:0] offset, [63] zero
  input  wire logic        s_axis_tuser_i,   // [0] action
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o    // [5:0] out_char, [7:6] zero
);
  import dcg_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_DIGITS);
  localparam int unsigned CIX_W = $clog2(MAX_DIGITS + 1);

  top_state_e                 state_q, state_d;
  logic [MAX_DIGITS-1:0][3:0] dig_q, dig_d, dig_inc, seek_dig;
  logic [LEN_W-1:0]           len_q, len_d, pos_q, pos_d, len_c, pos_c, k5;
  logic                       sep_q, sep_d;
  logic                       ovalid_q, ovalid_d;
  logic [CHAR_W-1:0]          ochar_q, ochar_d;
  logic [MAX_DIGITS:0]        carry;
  logic                       all9, s_fire, emit, seek;
  seek_res_t                  res;

  dcg_seek #(.MAX_DIGITS(MAX_DIGITS)) u_seek (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (seek),
    .offset_i (s_axis_tdata_i[OFF_W-1:0]),
    .res_o    (res),
    .digits_o (seek_dig)
  );

  // Take a word only between seeks and while the output can move.
  assign s_axis_tready_o = (state_q == T_IDLE) && (!ovalid_q || m_axis_tready_i);
  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign emit   = s_fire && s_axis_tuser_i;
  assign seek   = s_fire && !s_axis_tuser_i;

  // Clamp position and length into a valid digit index.
  assign len_c = (len_q == '0 || len_q > LEN_W'(MAX_DIGITS)) ? LEN_W'(1) : len_q;
  assign pos_c = (pos_q >= len_c) ? len_c - 1'b1 : pos_q;
  assign k5    = len_c - 1'b1 - pos_c;

  // BCD increment: a digit rolls when every digit below it is nine.
  always_comb begin
    carry[0] = 1'b1;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      carry[i+1] = carry[i] && (dig_q[i] == 4'd9);
      dig_inc[i] = carry[i] ? ((dig_q[i] == 4'd9) ? 4'd0 : dig_q[i] + 4'd1) : dig_q[i];
    end
  end
  assign all9 = carry[len_c[CIX_W-1:0]];

  always_comb begin
    state_d  = state_q;
    dig_d    = dig_q;
    len_d    = len_q;
    pos_d    = pos_q;
    sep_d    = sep_q;
    ovalid_d = ovalid_q;
    ochar_d  = ochar_q;
    if (m_axis_tready_i) ovalid_d = 1'b0;
    unique case (state_q)
      T_IDLE: begin
        if (seek) state_d = T_SEEK;
        if (emit) begin
          ovalid_d = 1'b1;
          if (sep_q) begin
            ochar_d = CHAR_SPACE;
            // Advance to the next number, wrap past the widest one.
            if (all9 && len_c == LEN_W'(MAX_DIGITS)) begin
              dig_d = '0;
              len_d = LEN_W'(1);
            end else begin
              dig_d = dig_inc;
              len_d = all9 ? len_c + 1'b1 : len_c;
            end
            pos_d = '0;
            sep_d = 1'b0;
          end else begin
            ochar_d = CHAR_ZERO + {2'b00, dig_q[k5[IDX_W-1:0]]};
            if (pos_c + 1'b1 >= len_c) begin
              pos_d = '0;
              sep_d = 1'b1;
            end else begin
              pos_d = pos_c + 1'b1;
            end
          end
        end
      end
      T_SEEK: begin
        if (res.done) begin
          state_d = T_IDLE;
          if (res.to_zero) begin
            dig_d = '0;
            len_d = LEN_W'(1);
            pos_d = '0;
            sep_d = 1'b0;
          end else begin
            dig_d = seek_dig;
            len_d = res.len;
            pos_d = (res.pos == res.len) ? '0 : res.pos;
            sep_d = (res.pos == res.len);
          end
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= T_IDLE;
      dig_q    <= '0;
      len_q    <= LEN_W'(1);
      pos_q    <= '0;
      sep_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      dig_q    <= dig_d;
      len_q    <= len_d;
      pos_q    <= pos_d;
      sep_q    <= sep_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ochar_q <= ochar_d;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {2'b00, ochar_q};

endmodule
`default_nettype wire

### hdl/dcg_checker.sv
// Port-level checker of the decimal count text generator and its bind.
`default_nettype none
`include "decimal_count_text_generator_unit_assert.svh"
module dcg_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid_i,
  input wire logic       s_axis_tready_o,
  input wire logic [63:0] s_axis_tdata_i,
  input wire logic       s_axis_tuser_i,
  input wire logic       m_axis_tvalid_o,
  input wire logic       m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_o
);

  `DCG_ASSERT_NOW(a_char_legal, m_axis_tvalid_o, (m_axis_tdata_o == 8'd32) || ((m_axis_tdata_o >= 8'd48) && (m_axis_tdata_o <= 8'd57)), "output word is not a space or digit")

  `DCG_ASSERT_NEXT(a_seek_blocks, s_axis_tvalid_i && s_axis_tready_o && !s_axis_tuser_i, !s_axis_tready_o, "word taken right after a seek")

  `DCG_ASSERT_NEXT(a_emit_gives, s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i, m_axis_tvalid_o, "emit gave no output word")

  `DCG_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled output word changed")

endmodule

bind decimal_count_text_generator_unit dcg_checker u_dcg_checker (.*);
`default_nettype wire

### test/decimal_count_text_generator_unit_tb.sv
// Self-checking testbench for the decimal count text generator: directed and random seeks and emits.
`default_nettype none
module decimal_count_text_generator_unit_tb;
  import dcg_pkg::*;

  localparam int unsigned DIGITS = 20;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam bit ACT_SEEK = 1'b0;
  localparam bit ACT_EMIT = 1'b1;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;

  decimal_count_text_generator_unit #(.MAX_DIGITS(DIGITS)) dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: current number in BCD, digit count, next digit, space flag.
  logic [3:0]       cur_digits [DIGITS];
  logic [LEN_W-1:0] cur_len;
  logic [LEN_W-1:0] cur_pos;
  bit               on_space;

  logic [CHAR_W-1:0] char_queue [$];
  int errors = 0;
  int words_seen = 0;
  int seeks_sent = 0;
  int emits_sent = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  bit timed_out = 1'b0;

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  function automatic void counter_to_zero();
    foreach (cur_digits[i]) cur_digits[i] = 4'd0;
    cur_len = 5'd1;
    cur_pos = '0;
    on_space = 1'b0;
  endfunction

  function automatic void counter_seek(input logic [62:0] off);
    logic [63:0] rest;
    logic [63:0] base;
    logic [63:0] cnt;
    logic [63:0] band;
    logic [63:0] num;
    logic [63:0] slot;
    int d;
    rest = {1'b0, off};
    base = 64'd1;
    for (d = 1; d < 19; d++) begin
      cnt = (d == 1) ? 64'd10 : 64'd9 * base;
      band = cnt * (d + 1);
      if (rest < band) break;
      rest -= band;
      base *= 10;
    end
    num = ((d == 1) ? 64'd0 : base) + rest / (d + 1);
    slot = rest % (d + 1);
    foreach (cur_digits[i]) cur_digits[i] = 4'd0;
    for (int i = 0; i < d; i++) begin
      cur_digits[i] = 4'(num % 10);
      num /= 10;
    end
    cur_len = LEN_W'(d);
    on_space = (slot == d);
    cur_pos = on_space ? '0 : slot[LEN_W-1:0];
  endfunction

  function automatic void counter_increment();
    for (int i = 0; i < cur_len; i++) begin
      if (cur_digits[i] < 4'd9) begin
        cur_digits[i]++;
        return;
      end
      cur_digits[i] = 4'd0;
    end
    if (cur_len < DIGITS) begin
      cur_digits[cur_len] = 4'd1;
      cur_len++;
    end else begin
      counter_to_zero();
    end
  endfunction

  function automatic logic [CHAR_W-1:0] next_char();
    logic [CHAR_W-1:0] ch;
    if (on_space) begin
      ch = CHAR_SPACE;
      counter_increment();
      cur_pos = '0;
      on_space = 1'b0;
    end else begin
      ch = CHAR_ZERO + cur_digits[cur_len - 1 - cur_pos];
      if (cur_pos + 1 >= cur_len) begin
        cur_pos = '0;
        on_space = 1'b1;
      end else begin
        cur_pos++;
      end
    end
    return ch;
  endfunction

  // Drive one word and hold it until accepted; predict on acceptance.
  // Valid stays high after acceptance so a following word can go back to back.
  task automatic send_word(input bit act, input logic [62:0] off, input int want);
    logic [CHAR_W-1:0] ch;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= act;
    s_axis_tdata_i  <= {1'b0, off};
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (act == ACT_SEEK) begin
      counter_seek(off);
      seeks_sent++;
    end else begin
      ch = next_char();
      if (want >= 0 && ch != want[CHAR_W-1:0])
        report_mismatch($sformatf("predictor gives %0d, table %0d", ch, want));
      char_queue.push_back(ch);
      emits_sent++;
    end
    @(negedge clk_i);
  endtask

  // Receiver: random stalls, compare each word against the oldest expectation.
  always @(negedge clk_i) m_axis_tready_i <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      words_seen++;
      if (char_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected word %0d", m_axis_tdata_o));
      end else begin
        if (m_axis_tdata_o[5:0] != char_queue[0] || m_axis_tdata_o[7:6] != 2'b00)
          report_mismatch($sformatf("char got %0d exp %0d",
                                    m_axis_tdata_o, char_queue[0]));
        void'(char_queue.pop_front());
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("decimal_count_text_generator_unit_tb: FAIL");
      $finish;
    end
  end

  // Directed table: action, offset, expected char (-1 = predictor only).
  typedef struct {
    bit          act;
    logic [62:0] off;
    int          want;
  } stim_row_t;

  stim_row_t plan [] = '{
    '{ACT_EMIT, 63'd0, 48}, '{ACT_EMIT, 63'd0, 32}, '{ACT_EMIT, 63'd0, 49},
    '{ACT_SEEK, 63'd19, -1}, '{ACT_EMIT, 63'd0, 32}, '{ACT_EMIT, 63'd0, 49},
    '{ACT_EMIT, 63'd0, 48}, '{ACT_SEEK, 63'd18, -1}, '{ACT_EMIT, 63'd0, 57},
    '{ACT_SEEK, 63'd22, -1}, '{ACT_EMIT, 63'd0, 32}, '{ACT_SEEK, 63'd289, -1},
    '{ACT_EMIT, 63'd0, -1}, '{ACT_EMIT, 63'd0, -1}, '{ACT_EMIT, 63'd0, -1},
    '{ACT_SEEK, 63'd0, -1}, '{ACT_EMIT, 63'd0, 48},
    '{ACT_SEEK, {63{1'b1}}, -1}, '{ACT_EMIT, 63'd0, -1}, '{ACT_EMIT, 63'd0, -1},
    '{ACT_SEEK, 63'h5555555555555555, -1}, '{ACT_EMIT, {63{1'b1}}, -1},
    '{ACT_SEEK, 63'd290, -1}, '{ACT_EMIT, 63'd0, 49}, '{ACT_EMIT, 63'd0, 48}
  };

  task automatic random_phase(input int idle, input int stall, input int count);
    logic [62:0] off;
    idle_pct = idle;
    stall_pct = stall;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 4) begin
        case ($urandom_range(2))
          0: off = 63'($urandom_range(300));
          1: off = 63'({$urandom, $urandom} >> $urandom_range(62));
          default: off = 63'({$urandom, $urandom});
        endcase
        send_word(ACT_SEEK, off, -1);
      end else begin
        send_word(ACT_EMIT, 63'({$urandom, $urandom}), -1);
      end
    end
  endtask

  initial begin
    counter_to_zero();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (plan[i]) send_word(plan[i].act, plan[i].off, plan[i].want);
    random_phase(0, 0, 270);
    random_phase(82, 0, 260);
    random_phase(0, 82, 260);
    random_phase(19, 19, 260);
    s_axis_tvalid_i <= 1'b0;
    stall_pct = 0;
    while (char_queue.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    $display("covered %0d seeks and %0d emits, %0d words checked",
             seeks_sent, emits_sent, words_seen);
    $display("idle and stall phases run: none, sender, receiver, both");
    if (errors == 0)
      $display("decimal_count_text_generator_unit_tb: PASS");
    else
      $display("decimal_count_text_generator_unit_tb: FAIL");
    $finish;
  end
endmodule
`default_nettype wire

### sim.f
+incdir+hdl
hdl/dcg_pkg.sv
hdl/dcg_seek.sv
hdl/decimal_count_text_generator_unit.sv
hdl/dcg_checker.sv
test/decimal_count_text_generator_unit_tb.sv
